>>> rtl/assert_macros.svh
// Assertion macros used by the port-level checker module of this project.
// Depends on nothing; the including file supplies clock, reset and message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/stau_pkg.sv
// Shared types and constants of the stack-top arithmetic unit.
// Depends on nothing; every other file of the block but stau_ram.sv and assert_macros.svh imports it.
package stau_pkg;

    localparam int DATA_W          = 32;
    localparam int MODE_W          = 3;
    localparam int STATUS_W        = 2;
    localparam int DEPTH_W         = 7;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int MIN_OPERANDS    = 2;

    localparam logic [MODE_W-1:0] MODE_PUSH = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SUB  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MUL  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DIV  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_MOD  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV
    } state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_RUN,
        DV_FIX,
        DV_DONE
    } div_state_t;

endpackage

>>> rtl/stau_ram.sv
// Single-port-write, single-port-read stack memory with registered read data.
// Depends on nothing outside this file.
module stau_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/stau_div.sv
// Iterative signed divider: one restoring step per cycle, truncating toward zero.
// Depends on stau_pkg for the data width and the divider state type.
module stau_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [stau_pkg::DATA_W-1:0] dividend,
    input  logic [stau_pkg::DATA_W-1:0] divisor,
    output logic                       done,
    output logic [stau_pkg::DATA_W-1:0] quotient,
    output logic [stau_pkg::DATA_W-1:0] remainder
);
    import stau_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    div_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] dsr_reg, dsr_next;
    logic              neg_q_reg, neg_q_next;
    logic              neg_r_reg, neg_r_next;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dsr_reg   <= dsr_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

    // One restoring step: shift in the next dividend bit and try to subtract.
    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    quo_next   = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
                    dsr_next   = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
                    rem_next   = '0;
                    cnt_next   = '0;
                    neg_q_next = dividend[DATA_W-1] ^ divisor[DATA_W-1];
                    neg_r_next = dividend[DATA_W-1];
                    state_next = DV_RUN;
                end
            end
            DV_RUN:
            begin
                if (!diff[DATA_W])
                begin
                    rem_next = diff[DATA_W-1:0];
                end
                else
                begin
                    rem_next = shifted[DATA_W-1:0];
                end
                quo_next = {quo_reg[DATA_W-2:0], ~diff[DATA_W]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DATA_W - 1))
                begin
                    state_next = DV_FIX;
                end
            end
            DV_FIX:
            begin
                // The quotient takes the sign of the operands' product and the
                // remainder that of the dividend.
                quo_next   = neg_q_reg ? (~quo_reg + 1'b1) : quo_reg;
                rem_next   = neg_r_reg ? (~rem_reg + 1'b1) : rem_reg;
                state_next = DV_DONE;
            end
            DV_DONE:
            begin
                state_next = DV_IDLE;
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    assign done      = (state_reg == DV_DONE);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/stack_top_arithmetic_unit.sv
// Top level of the stack-top arithmetic unit: sequencer, stack memory, result register.
// Depends on stau_pkg, stau_ram and stau_div.
//
//  Channel   Handshake                Payload
//  cmd       cmd_valid / cmd_stall    mode, push_value
//  rsp       rsp_valid / rsp_stall    status, top_value, stack_depth
//
// Push, push onto a full stack, an unused mode and an operation on fewer
// than two entries put their result beat in the result register in the
// cycle after acceptance. Add, sub, mul and a divide by zero first pass the
// execute state; div and mod then also wait for the 32 single-bit divider steps.
// Reset empties the stack; the memory contents are left as they are.
// A new command beat is taken only while the sequencer is idle and the
// result register is empty or being emptied in the same cycle.
module stack_top_arithmetic_unit #(
    parameter int STACK_DEPTH = stau_pkg::STACK_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  logic [stau_pkg::MODE_W-1:0]   mode,
    input  logic signed [stau_pkg::DATA_W-1:0] push_value,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic [stau_pkg::STATUS_W-1:0] status,
    output logic signed [stau_pkg::DATA_W-1:0] top_value,
    output logic [stau_pkg::DEPTH_W-1:0]  stack_depth
);
    import stau_pkg::*;

    // Entry count runs from zero to STACK_DEPTH inclusive; addresses need one bit less
    // when the depth is a power of two.
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [DATA_W-1:0]  top_reg, top_next;
    logic [MODE_W-1:0]  mode_reg, mode_next;

    logic                rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0] rsp_status_reg, rsp_status_next;
    logic [DATA_W-1:0]   rsp_top_reg, rsp_top_next;
    logic [DEPTH_W-1:0]  rsp_depth_reg, rsp_depth_next;

    logic                ram_we;
    logic [AW-1:0]       ram_wr_addr;
    logic [DATA_W-1:0]   ram_wr_data;
    logic [DATA_W-1:0]   ram_rd_data;

    logic                div_start;
    logic                div_done;
    logic [DATA_W-1:0]   div_quo;
    logic [DATA_W-1:0]   div_rem;

    logic                cmd_accept;
    logic [CW-1:0]       count_m1;
    logic [CW-1:0]       count_m2;
    logic [AW-1:0]       second_addr;
    logic [DATA_W-1:0]   alu_s;
    logic [DATA_W-1:0]   alu_t;
    logic                load_rsp;
    logic [STATUS_W-1:0] load_status;
    logic                op_finish;
    logic [DATA_W-1:0]   op_result;

    assign count_m1    = count_reg - CW'(1);
    assign count_m2    = count_reg - CW'(MIN_OPERANDS);
    assign second_addr = count_m2[AW-1:0];

    // The entry below the top is read on every cycle; it is consumed in the execute
    // state that follows an accepted operation beat, when the count has not yet moved.
    stau_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (DATA_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (second_addr),
        .rd_data (ram_rd_data)
    );

    // The top of the stack is kept in top_reg, so only the second operand
    // comes from memory.
    assign alu_s = ram_rd_data;
    assign alu_t = top_reg;

    stau_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (alu_s),
        .divisor   (alu_t),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign cmd_stall  = (state_reg != S_IDLE) || (rsp_valid_reg && rsp_stall);
    assign cmd_accept = cmd_valid && !cmd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg        <= top_next;
        mode_reg       <= mode_next;
        rsp_status_reg <= rsp_status_next;
        rsp_top_reg    <= rsp_top_next;
        rsp_depth_reg  <= rsp_depth_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        top_next    = top_reg;
        mode_next   = mode_reg;
        ram_we      = 1'b0;
        ram_wr_addr = count_reg[AW-1:0];
        ram_wr_data = push_value;
        div_start   = 1'b0;
        load_rsp    = 1'b0;
        load_status = ST_OK;
        op_finish   = 1'b0;
        op_result   = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    mode_next = mode;
                    case (mode)
                        MODE_PUSH:
                        begin
                            load_rsp = 1'b1;
                            if (count_reg == CW'(STACK_DEPTH))
                            begin
                                load_status = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                                top_next   = push_value;
                            end
                        end
                        MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MOD:
                        begin
                            if (count_reg < CW'(MIN_OPERANDS))
                            begin
                                load_rsp    = 1'b1;
                                load_status = ST_SHORT;
                                count_next  = '0;
                            end
                            else
                            begin
                                state_next = S_EXEC;
                            end
                        end
                        default:
                        begin
                            // Unused modes leave the stack alone and report it.
                            load_rsp = 1'b1;
                        end
                    endcase
                end
            end
            S_EXEC:
            begin
                case (mode_reg)
                    MODE_ADD:
                    begin
                        op_finish = 1'b1;
                        op_result = alu_s + alu_t;
                    end
                    MODE_SUB:
                    begin
                        op_finish = 1'b1;
                        op_result = alu_s - alu_t;
                    end
                    MODE_MUL:
                    begin
                        op_finish = 1'b1;
                        op_result = DATA_W'(alu_s * alu_t);
                    end
                    default:
                    begin
                        // Divide and remainder share the iterative divider.
                        if (alu_t == '0)
                        begin
                            load_rsp    = 1'b1;
                            load_status = ST_DIVZERO;
                            count_next  = '0;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    op_finish = 1'b1;
                    op_result = (mode_reg == MODE_DIV) ? div_quo : div_rem;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A finished operation replaces the second entry and pops the top.
        if (op_finish)
        begin
            ram_we      = 1'b1;
            ram_wr_addr = second_addr;
            ram_wr_data = op_result;
            count_next  = count_m1;
            top_next    = op_result;
            load_rsp    = 1'b1;
            state_next  = S_IDLE;
        end
    end

    // Result register: loaded only when it is empty or being emptied, which the
    // command-side stall guarantees.
    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_status_next = rsp_status_reg;
        rsp_top_next    = rsp_top_reg;
        rsp_depth_next  = rsp_depth_reg;
        if (load_rsp)
        begin
            rsp_valid_next  = 1'b1;
            rsp_status_next = load_status;
            rsp_top_next    = (count_next == '0) ? '0 : top_next;
            rsp_depth_next  = DEPTH_W'(count_next);
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = rsp_status_reg;
    assign top_value   = rsp_top_reg;
    assign stack_depth = rsp_depth_reg;

endmodule

>>> rtl/stau_checker.sv
// Port-level checker for the stack-top arithmetic unit, bound to the top level.
// Depends on stau_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stau_assertions #(
    parameter int STACK_DEPTH = stau_pkg::STACK_DEPTH_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_stall,
    input logic                          rsp_valid,
    input logic                          rsp_stall,
    input logic [stau_pkg::STATUS_W-1:0] status,
    input logic [stau_pkg::DATA_W-1:0]   top_value,
    input logic [stau_pkg::DEPTH_W-1:0]  stack_depth
);
    import stau_pkg::*;

    logic                               rsp_held;
    logic                               rsp_empty;
    logic                               rsp_error;
    logic                               rsp_full;
    logic                               depth_full;
    logic [STATUS_W+DATA_W+DEPTH_W-1:0] rsp_beat;

    assign rsp_held   = rsp_valid && rsp_stall;
    assign rsp_empty  = rsp_valid && (stack_depth == '0);
    assign rsp_error  = rsp_valid && (status == ST_SHORT || status == ST_DIVZERO);
    assign rsp_full   = rsp_valid && (status == ST_FULL);
    assign depth_full = (stack_depth == DEPTH_W'(STACK_DEPTH));
    assign rsp_beat   = {status, top_value, stack_depth};

    // A stalled result beat stays put.
    `ASSERT_NEXT(a_hold, clk, rst_n, rsp_held, rsp_valid && $stable(rsp_beat), "beat changed")

    // A waiting result beat blocks the command side.
    `ASSERT_SAME(a_cmd_block, clk, rst_n, rsp_held, cmd_stall, "command taken while full")

    // An empty stack shows a zero top value.
    `ASSERT_SAME(a_empty_top, clk, rst_n, rsp_empty, top_value == '0, "empty top not zero")

    // Both operation errors leave the stack empty.
    `ASSERT_SAME(a_error_empty, clk, rst_n, rsp_error, stack_depth == '0, "error left entries")

    // A refused push only happens on a full stack.
    `ASSERT_SAME(a_full_depth, clk, rst_n, rsp_full, depth_full, "full below depth")

endmodule

bind stack_top_arithmetic_unit stau_assertions #(
    .STACK_DEPTH (STACK_DEPTH)
) u_stau_assertions (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_stall   (cmd_stall),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .top_value   (top_value),
    .stack_depth (stack_depth)
);

>>> sim/stau_checker.sv
// Checker for the stack-top arithmetic unit: watches both channels, predicts each result beat
// and compares it field by field. Depends on stau_pkg for widths, modes and status codes.
module stau_checker #(
    parameter int STACK_DEPTH = stau_pkg::STACK_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_valid,
    input  logic                                 cmd_stall,
    input  logic [stau_pkg::MODE_W-1:0]          mode,
    input  logic signed [stau_pkg::DATA_W-1:0]   push_value,
    input  logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    input  logic [stau_pkg::STATUS_W-1:0]        status,
    input  logic signed [stau_pkg::DATA_W-1:0]   top_value,
    input  logic [stau_pkg::DEPTH_W-1:0]         stack_depth,
    output int                                   fail_count,
    output int                                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import stau_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0]        status;
        logic signed [DATA_W-1:0]   top;
        logic [DEPTH_W-1:0]         depth;
    } stack_result_t;

    logic signed [DATA_W-1:0] shadow_stack [STACK_DEPTH];
    int                       shadow_count;
    stack_result_t            expected_results [$];
    stack_result_t            oldest;
    int                       mismatches;

    task automatic report_mismatch(input string field, input longint want, input longint got);
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        mismatches++;
    endtask

    // Applies one command beat to the shadow stack and returns the result it must produce.
    function automatic stack_result_t apply_command(input logic [MODE_W-1:0] m,
                                                    input logic signed [DATA_W-1:0] v);
        stack_result_t r;
        longint        s;
        longint        t;
        longint        q;
        r.status = ST_OK;
        q = 0;
        if (m == MODE_PUSH) begin
            if (shadow_count >= STACK_DEPTH) begin
                r.status = ST_FULL;
            end
            else begin
                shadow_stack[shadow_count] = v;
                shadow_count++;
            end
        end
        else if (m <= MODE_MOD) begin
            if (shadow_count < MIN_OPERANDS) begin
                r.status = ST_SHORT;
                shadow_count = 0;
            end
            else begin
                t = longint'(shadow_stack[shadow_count-1]);
                s = longint'(shadow_stack[shadow_count-2]);
                if ((m == MODE_DIV || m == MODE_MOD) && t == 0) begin
                    r.status = ST_DIVZERO;
                    shadow_count = 0;
                end
                else begin
                    // 64-bit arithmetic keeps the most negative over minus one well defined.
                    case (m)
                        MODE_ADD: q = s + t;
                        MODE_SUB: q = s - t;
                        MODE_MUL: q = s * t;
                        MODE_DIV: q = s / t;
                        default:  q = s % t;
                    endcase
                    shadow_count--;
                    shadow_stack[shadow_count-1] = q[DATA_W-1:0];
                end
            end
        end
        r.top   = (shadow_count != 0) ? shadow_stack[shadow_count-1] : '0;
        r.depth = shadow_count[DEPTH_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            shadow_count = 0;
            mismatches   = 0;
            expected_results.delete();
            fail_count  <= 0;
            pending     <= 0;
        end
        else begin
            // A result beat always belongs to an earlier command, so check before predicting.
            if (rsp_valid && !rsp_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result beat", 0, 1);
                end
                else begin
                    oldest = expected_results.pop_front();
                    if (status !== oldest.status)
                        report_mismatch("status", oldest.status, status);
                    if (top_value !== oldest.top)
                        report_mismatch("top_value", oldest.top, top_value);
                    if (stack_depth !== oldest.depth)
                        report_mismatch("stack_depth", oldest.depth, stack_depth);
                end
            end
            if (cmd_valid && !cmd_stall)
                expected_results.push_back(apply_command(mode, push_value));
            pending    <= expected_results.size();
            fail_count <= mismatches;
        end
    end

endmodule

>>> sim/tb_top.sv
// Top of the stack-top arithmetic unit testbench: clock, reset, command stimulus and verdict.
// Depends on stau_pkg, the block itself and stau_checker, which predicts and compares every result beat.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import stau_pkg::*;

    localparam int DEPTH       = STACK_DEPTH_DEF;
    // Generous ceiling: even at a full divide latency plus long gaps on both sides for
    // every beat, a correct run of about 700 beats stays far below this.
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 60;

    // Modes 6 and 7 are unused codes; the block must leave the stack alone for them.
    localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cmd_valid;
    logic                       cmd_stall;
    logic [MODE_W-1:0]          mode;
    logic signed [DATA_W-1:0]   push_value;
    logic                       rsp_valid;
    logic                       rsp_stall;
    logic [STATUS_W-1:0]        status;
    logic signed [DATA_W-1:0]   top_value;
    logic [DEPTH_W-1:0]         stack_depth;

    int   fail_count;
    int   pending;
    int   beats_sent;
    int   cycle_count;
    int   send_idle_pct;
    int   rsp_idle_pct = 58;
    logic hold_go;
    logic hold_rsp;

    stack_top_arithmetic_unit #(
        .STACK_DEPTH (DEPTH)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .mode        (mode),
        .push_value  (push_value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .top_value   (top_value),
        .stack_depth (stack_depth)
    );

    stau_checker #(
        .STACK_DEPTH (DEPTH)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .mode        (mode),
        .push_value  (push_value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .top_value   (top_value),
        .stack_depth (stack_depth),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // 20 ns clock period.
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver side: stall at random by the current percentage, or solidly while the
    // long hold-off is active.
    initial begin
        rsp_stall = 1'b0;
        forever begin
            @(posedge clk);
            rsp_stall <= hold_rsp || ($urandom_range(0, 99) < rsp_idle_pct);
        end
    end

    // Long receiver hold-off, counted here. The sender keeps offering beats meanwhile, so
    // the result register fills and the block has to stall its command side.
    initial begin
        hold_rsp = 1'b0;
        @(posedge clk);
        while (!hold_go)
            @(posedge clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp <= 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Offers one command beat and returns at the edge where it is accepted. Random idle
    // cycles before the beat put gaps on every phase of the block's work.
    task automatic send_cmd(input logic [MODE_W-1:0] m, input logic signed [DATA_W-1:0] v);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid  <= 1'b1;
        mode       <= m;
        push_value <= v;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    // Stops offering beats until the checker holds no outstanding expectation. The first
    // edge lets the checker's count take in the beat accepted just before.
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Operand values lean on the interesting points: zero, plus and minus one, the
    // extremes and small magnitudes, with fully random words for the rest.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int n;
        n = $urandom_range(0, 400);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return -1;
            2:       return 1;
            3:       return VAL_MIN;
            4:       return VAL_MAX;
            5, 6:    return n - 200;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] pick_op();
        case ($urandom_range(0, 4))
            0:       return MODE_ADD;
            1:       return MODE_SUB;
            2:       return MODE_MUL;
            3:       return MODE_DIV;
            default: return MODE_MOD;
        endcase
    endfunction

    // Pushes DEPTH to DEPTH + 4 times, so the stack is surely full, then unwinds with operations.
    task automatic fill_and_unwind();
        repeat ($urandom_range(DEPTH, DEPTH + 4)) send_cmd(MODE_PUSH, pick_value());
        repeat ($urandom_range(3, DEPTH + 6)) send_cmd(pick_op(), pick_value());
    endtask

    // Random traffic: mostly well-formed expressions (n pushes then n-1 operations, so the
    // stack creeps deeper), now and then a full-stack burst, noise on all eight modes, and
    // bare operations that run into a short stack.
    task automatic run_batch(input int count);
        int target;
        int kind;
        int n;
        target = beats_sent + count;
        while (beats_sent < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                n = $urandom_range(2, 6);
                repeat (n) send_cmd(MODE_PUSH, pick_value());
                repeat (n - 1) send_cmd(pick_op(), pick_value());
            end
            else if (kind < 73) begin
                fill_and_unwind();
            end
            else if (kind < 87) begin
                repeat ($urandom_range(1, 4)) send_cmd(MODE_W'($urandom_range(0, 7)), $urandom());
            end
            else begin
                repeat ($urandom_range(1, 3)) send_cmd(pick_op(), pick_value());
            end
        end
    endtask

    initial begin
        rst_n         = 1'b0;
        cmd_valid     = 1'b0;
        mode          = MODE_PUSH;
        push_value    = '0;
        hold_go       = 1'b0;
        beats_sent    = 0;
        send_idle_pct = 22;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats, run under the first idling pattern.
        send_cmd(MODE_ADD, VAL_MAX);        // operation on an empty stack
        send_cmd(MODE_PUSH, VAL_MAX);
        send_cmd(MODE_DIV, '0);             // operation on a single entry
        send_cmd(MODE_PUSH, VAL_MAX);
        send_cmd(MODE_PUSH, 1);
        send_cmd(MODE_ADD, -1);             // wraps to the most negative value
        send_cmd(MODE_PUSH, 1);
        send_cmd(MODE_SUB, VAL_MIN);        // wraps back to the most positive value
        send_cmd(MODE_PUSH, -1);
        send_cmd(MODE_MUL, '0);
        send_cmd(MODE_PUSH, '0);
        send_cmd(MODE_MOD, -1);             // remainder by zero empties the stack
        send_cmd(MODE_PUSH, VAL_MIN);
        send_cmd(MODE_PUSH, -1);
        send_cmd(MODE_DIV, VAL_MAX);        // most negative over minus one wraps
        send_cmd(MODE_PUSH, -1);
        send_cmd(MODE_MOD, '0);             // and its remainder is zero
        send_cmd(MODE_PUSH, 7);
        send_cmd(MODE_PUSH, -2);
        send_cmd(MODE_DIV, 1);              // truncation toward zero on a negative quotient
        send_cmd(MODE_PUSH, 2);
        send_cmd(MODE_MOD, VAL_MIN);        // remainder takes the sign of the dividend
        send_cmd(MODE_SPARE6, $urandom());
        send_cmd(MODE_SPARE7, $urandom());
        send_cmd(MODE_PUSH, '0);
        send_cmd(MODE_DIV, -1);             // quotient by zero empties the stack
        wait_drained();

        // First phase: sender idles lightly, receiver heavily. The full-stack case comes
        // first, and the long receiver hold-off lands in the middle.
        fill_and_unwind();
        run_batch(100);
        hold_go <= 1'b1;
        run_batch(90);
        wait_drained();

        // Second phase: the other way round.
        send_idle_pct = 58;
        rsp_idle_pct <= 22;
        run_batch(190);
        wait_drained();

        // Third phase: back to back on both sides.
        send_idle_pct = 0;
        rsp_idle_pct <= 0;
        run_batch(190);
        wait_drained();

        // Leave room for any stray result beat to show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
